FILE: design/rbta_pkg.sv
package rbta_pkg;

    localparam int unsigned HALF_WIDTH_DEF  = 106;
    localparam int unsigned HALF_HEIGHT_DEF = 66;
    localparam int unsigned TAP_COUNT_DEF   = 4;

    localparam logic [15:0] STRIDE_RESET = 16'd320;

    // Quadrant codes.
    localparam logic [1:0] QUAD_UPPER_LEFT  = 2'd0;
    localparam logic [1:0] QUAD_UPPER_RIGHT = 2'd1;
    localparam logic [1:0] QUAD_LOWER_LEFT  = 2'd2;
    localparam logic [1:0] QUAD_LOWER_RIGHT = 2'd3;

    // Magnitude of a centred coordinate and width of the squared distance.
    localparam int MAG_W  = 9;
    localparam int DIST_W = 2 * MAG_W + 1;

    typedef struct packed {
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [1:0] tap_index;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] byte_offset;
        logic [6:0]  x_blend;
        logic [6:0]  y_blend;
        logic [1:0]  quadrant;
        logic [6:0]  table_row;
        logic [6:0]  table_col;
    } t_out_beat;

    // Per-item information that rides alongside the root lanes.
    typedef struct packed {
        logic [1:0] quadrant;
        logic [6:0] table_row;
        logic [6:0] table_col;
        logic       neg_x;
        logic       neg_y;
        logic       centre;
    } t_side;

endpackage

FILE: design/rbta_front.sv
module rbta_front import rbta_pkg::*; #(
    parameter int unsigned HALF_WIDTH  = HALF_WIDTH_DEF,
    parameter int unsigned HALF_HEIGHT = HALF_HEIGHT_DEF,
    parameter int unsigned TAP_COUNT   = TAP_COUNT_DEF,
    parameter int          NW          = 11,
    parameter int          SW          = 40
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  t_in_beat            i_data,
    output logic [SW-1:0]       o_sq_x,
    output logic [SW-1:0]       o_sq_y,
    output logic [DIST_W-1:0]   o_dist,
    output t_side               o_side
);

    localparam int NUM_W = NW + MAG_W;

    logic signed [9:0]   fx, fy;
    logic [1:0]          tap_sat;
    logic [NW-1:0]       n_len;
    t_side               side0;

    logic [MAG_W-1:0]    r_mx, r_my;
    logic [NW-1:0]       r_n;
    t_side               r_side1;
    logic [DIST_W-1:0]   r_d2;
    logic [NUM_W-1:0]    r_numx, r_numy;
    t_side               r_side2;
    logic [SW-1:0]       r_sqx, r_sqy;
    logic [DIST_W-1:0]   r_d3;
    t_side               r_side3;

    always_comb begin
        fx = signed'({2'b00, i_data.pos_x}) - signed'(10'(HALF_WIDTH - 1));
        fy = signed'({2'b00, i_data.pos_y}) - signed'(10'(HALF_HEIGHT - 1));
        tap_sat = (int'(i_data.tap_index) > int'(TAP_COUNT) - 1)
                  ? 2'(TAP_COUNT - 1) : i_data.tap_index;
        n_len = NW'((int'(tap_sat) + 1) * 256);
        side0 = '0;
        side0.neg_x  = (fx > 0);
        side0.neg_y  = (fy > 0);
        side0.centre = (fx == '0) && (fy == '0);
        if (int'(i_data.pos_y) < int'(HALF_HEIGHT)) begin
            side0.table_row = 7'(int'(HALF_HEIGHT) - 1 - int'(i_data.pos_y));
            side0.quadrant  = QUAD_UPPER_LEFT;
        end else begin
            side0.table_row = 7'(int'(i_data.pos_y) - int'(HALF_HEIGHT));
            side0.quadrant  = QUAD_LOWER_LEFT;
        end
        if (int'(i_data.pos_x) < int'(HALF_WIDTH)) begin
            side0.table_col = 7'(int'(HALF_WIDTH) - 1 - int'(i_data.pos_x));
        end else begin
            side0.table_col = 7'(int'(i_data.pos_x) - int'(HALF_WIDTH));
            side0.quadrant  = side0.quadrant | QUAD_UPPER_RIGHT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mx    <= fx[9] ? MAG_W'(-fx) : MAG_W'(fx);
            r_my    <= fy[9] ? MAG_W'(-fy) : MAG_W'(fy);
            r_n     <= n_len;
            r_side1 <= side0;

            r_d2    <= DIST_W'(r_mx) * DIST_W'(r_mx) + DIST_W'(r_my) * DIST_W'(r_my);
            r_numx  <= NUM_W'(r_n) * NUM_W'(r_mx);
            r_numy  <= NUM_W'(r_n) * NUM_W'(r_my);
            r_side2 <= r_side1;

            r_sqx   <= SW'(r_numx) * SW'(r_numx);
            r_sqy   <= SW'(r_numy) * SW'(r_numy);
            r_d3    <= r_d2;
            r_side3 <= r_side2;
        end
    end

    assign o_sq_x = r_sqx;
    assign o_sq_y = r_sqy;
    assign o_dist = r_d3;
    assign o_side = r_side3;

endmodule

FILE: design/rbta_root.sv
module rbta_root import rbta_pkg::*; #(
    parameter int NW = 11,
    parameter int SW = 40
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [SW-1:0]     i_sq,
    input  logic [DIST_W-1:0] i_dist,
    output logic [NW-1:0]     o_root
);

    // Finds the largest m with m*m*d <= sq, one bit per stage, keeping
    // m*m*d and m*d as running sums so every stage is shifts and adds.
    localparam int PW = 2 * NW + DIST_W + 2;
    localparam int QW = NW + DIST_W + 1;

    logic [PW-1:0]     r_p  [NW];
    logic [QW-1:0]     r_q  [NW];
    logic [NW-1:0]     r_m  [NW];
    logic [SW-1:0]     r_sq [NW];
    logic [DIST_W-1:0] r_d  [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        localparam int B = NW - 1 - k;
        logic [PW-1:0]     p_in, cand;
        logic [QW-1:0]     q_in;
        logic [NW-1:0]     m_in;
        logic [SW-1:0]     sq_in;
        logic [DIST_W-1:0] d_in;
        logic              take;

        if (k == 0) begin : g_first
            assign p_in  = '0;
            assign q_in  = '0;
            assign m_in  = '0;
            assign sq_in = i_sq;
            assign d_in  = i_dist;
        end else begin : g_next
            assign p_in  = r_p[k-1];
            assign q_in  = r_q[k-1];
            assign m_in  = r_m[k-1];
            assign sq_in = r_sq[k-1];
            assign d_in  = r_d[k-1];
        end

        assign cand = p_in + (PW'(q_in) << (B + 1)) + (PW'(d_in) << (2 * B));
        assign take = (cand <= PW'(sq_in));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[k]  <= take ? cand : p_in;
                r_q[k]  <= take ? q_in + (QW'(d_in) << B) : q_in;
                r_m[k]  <= take ? (m_in | (NW'(1) << B)) : m_in;
                r_sq[k] <= sq_in;
                r_d[k]  <= d_in;
            end
        end
    end

    assign o_root = r_m[NW-1];

endmodule

FILE: design/radial_blur_tap_address.sv
// Channel  | Direction | Handshake                  | Payload
// input    | in        | i_valid / o_stall          | i_data (t_in_beat)
// output   | out       | o_valid / i_stall          | o_data (t_out_beat)
// config   | in        | i_cfg_we                   | i_cfg_wdata (row stride)
//
// One beat is accepted per cycle unless o_stall is high; the pipeline is the front stages,
// the root stages, where NW is the width of the longest step (11 for four taps),
// and the output register. The root lanes resolve one bit of the step per stage.
// Reset is synchronous and active low; it empties the pipeline and sets the stride
// to 320. A stall on a held result freezes every stage at once, so nothing is lost.
module radial_blur_tap_address import rbta_pkg::*; #(
    parameter int unsigned HALF_WIDTH  = HALF_WIDTH_DEF,
    parameter int unsigned HALF_HEIGHT = HALF_HEIGHT_DEF,
    parameter int unsigned TAP_COUNT   = TAP_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_beat    i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_beat   o_data,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    // Step magnitude never exceeds the step length, TAP_COUNT * 256.
    localparam int NW  = $clog2(TAP_COUNT * 256 + 1);
    localparam int SW  = 2 * (NW + MAG_W);
    localparam int LAT = 4 + NW;

    logic [15:0]       r_stride;
    logic [LAT-1:0]    r_valid;
    logic              adv;

    logic [SW-1:0]     sq_x, sq_y;
    logic [DIST_W-1:0] dist_sq;
    t_side             side_f;
    t_side             r_side [NW];
    logic [NW-1:0]     m_x, m_y;

    logic signed [NW:0] sx, sy;
    logic [15:0]        hx, hy;
    t_side              side_l;
    t_out_beat          r_out;

    // The whole pipeline moves together unless a finished beat is held.
    assign adv     = !(r_valid[LAT-1] && i_stall);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= STRIDE_RESET;
            r_valid  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_stride <= i_cfg_wdata;
            end
            if (adv) begin
                r_valid <= {r_valid[LAT-2:0], i_valid};
            end
        end
    end

    rbta_front #(
        .HALF_WIDTH (HALF_WIDTH),
        .HALF_HEIGHT(HALF_HEIGHT),
        .TAP_COUNT  (TAP_COUNT),
        .NW         (NW),
        .SW         (SW)
    ) u_front (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_data(i_data),
        .o_sq_x(sq_x),
        .o_sq_y(sq_y),
        .o_dist(dist_sq),
        .o_side(side_f)
    );

    rbta_root #(.NW(NW), .SW(SW)) u_root_x (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_sq  (sq_x),
        .i_dist(dist_sq),
        .o_root(m_x)
    );

    rbta_root #(.NW(NW), .SW(SW)) u_root_y (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_sq  (sq_y),
        .i_dist(dist_sq),
        .o_root(m_y)
    );

    // Side information is delayed to line up with the root lanes.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[0] <= side_f;
            for (int i = 1; i < NW; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // The centre pixel has no direction, so both steps are forced to zero.
    // Otherwise the step points toward the centre, hence the sign flip.
    always_comb begin
        side_l = r_side[NW-1];
        if (side_l.centre) begin
            sx = '0;
            sy = '0;
        end else begin
            sx = side_l.neg_x ? -signed'({1'b0, m_x}) : signed'({1'b0, m_x});
            sy = side_l.neg_y ? -signed'({1'b0, m_y}) : signed'({1'b0, m_y});
        end
        // Arithmetic shift gives the floor of the whole-pixel part.
        hx = 16'(sx >>> 8);
        hy = 16'(sy >>> 8);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.byte_offset <= 16'(hy * r_stride) + hx;
            r_out.x_blend     <= sx[7:1];
            r_out.y_blend     <= sy[7:1];
            r_out.quadrant    <= side_l.quadrant;
            r_out.table_row   <= side_l.table_row;
            r_out.table_col   <= side_l.table_col;
        end
    end

    assign o_valid = r_valid[LAT-1];
    assign o_data  = r_out;

endmodule

FILE: design/rbta_checker.sv
module rbta_checker import rbta_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_stall,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_beat o_data
);

    // The input side only backs up when a finished beat is held.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow a held output beat");

    // No result can be left over from before reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // A held output beat keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("held output beat changed");

    // With the input stalled, the held output beat must stay valid.
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> o_valid)
        else $error("pipeline moved during a stall");

endmodule

bind radial_blur_tap_address rbta_checker u_rbta_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .o_stall(o_stall),
    .o_valid(o_valid),
    .i_stall(i_stall),
    .o_data (o_data)
);
